/* hdl/rank_filter_3x3_defines.svh */
// Assertion macros for the rank filter.
// Used by the top level; needs a signal named clock and one named reset in scope.
`ifndef RANK_FILTER_3X3_DEFINES_SVH
`define RANK_FILTER_3X3_DEFINES_SVH
`ifndef SYNTHESIS
`define RF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rank filter check failed");
`define RF_ASSERT_RESET(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("rank filter reset check failed");
`else
`define RF_ASSERT(lbl, prop)
`define RF_ASSERT_RESET(lbl, prop)
`endif
`endif

/* hdl/rf_pkg.sv */
// Shared types and constants of the 3x3 rank filter.
// Depends on nothing; used by every module of the filter.
package rf_pkg;

   localparam int PIX_BITS      = 8;
   localparam int ROW_BITS      = 12;
   localparam int IW_BITS       = 11;
   localparam int RANK_BITS     = 4;
   localparam int WIN_SIZE      = 9;
   localparam int SLOT_BITS     = 2;
   localparam int N_SLOTS       = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 12;

   localparam logic [RANK_BITS-1:0] RANK_MAX = 4'd8;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANK_SELECT  = 2'd2;

   // Reset values of the registers.
   localparam logic [IW_BITS-1:0]   IW_RESET   = 11'd640;
   localparam logic [ROW_BITS-1:0]  IH_RESET   = 12'd480;
   localparam logic [RANK_BITS-1:0] RANK_RESET = 4'd4;

   // Item kinds on the request channel.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef logic [PIX_BITS-1:0] pixel_type;

   // One window column: the sample above, at and below the centre row.
   typedef struct packed {
      pixel_type up;
      pixel_type mid;
      pixel_type dn;
   } column_type;

   // Line store row slots feeding the three window rows.
   typedef struct packed {
      logic [SLOT_BITS-1:0] up;
      logic [SLOT_BITS-1:0] mid;
      logic [SLOT_BITS-1:0] dn;
   } slots_type;

   typedef pixel_type [WIN_SIZE-1:0] window_type;

endpackage

/* hdl/rf_line_store.sv */
// Line store of the rank filter: four row banks, one write and two reads per bank.
// Depends on rf_pkg.
module rf_line_store
   import rf_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [SLOT_BITS-1:0]         wr_slot,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  pixel_type                    wr_data,
   input  logic                         rd_en,
   input  slots_type                    rd_slots,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_c,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_r,
   output column_type                   center,
   output column_type                   right
);

   pixel_type bank_c [N_SLOTS];
   pixel_type bank_r [N_SLOTS];
   slots_type slots_ff;

   // Each bank holds the rows whose index modulo four is its slot number.
   for (genvar b = 0; b < N_SLOTS; b++) begin : g_bank
      pixel_type mem [MAX_WIDTH];
      pixel_type rdc_ff;
      pixel_type rdr_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_slot == SLOT_BITS'(b))) begin
            mem[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rdc_ff <= mem[rd_addr_c];
            rdr_ff <= mem[rd_addr_r];
         end
      end

      assign bank_c[b] = rdc_ff;
      assign bank_r[b] = rdr_ff;
   end

   // The slot choice travels with the read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         slots_ff <= rd_slots;
      end
   end

   // Pick the three rows of the window out of the four banks.
   always_comb begin
      center.up  = bank_c[slots_ff.up];
      center.mid = bank_c[slots_ff.mid];
      center.dn  = bank_c[slots_ff.dn];
      right.up   = bank_r[slots_ff.up];
      right.mid  = bank_r[slots_ff.mid];
      right.dn   = bank_r[slots_ff.dn];
   end

endmodule

/* hdl/rf_column_cell.sv */
// One window cell of the rank filter: holds a three-sample column.
// Depends on rf_pkg; cells are chained so each one takes its neighbour's column.
module rf_column_cell
   import rf_pkg::*;
(
   input  logic       clock,
   input  logic       load,
   input  logic       take_alt,
   input  column_type nb_in,
   input  column_type alt_in,
   output column_type col_out
);

   column_type col_ff;
   column_type col_in;

   // At a row start the cell takes the fresh column instead of its neighbour's.
   assign col_in = take_alt ? alt_in : nb_in;

   always_ff @(posedge clock) begin
      if (load) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

/* hdl/rf_rank_unit.sv */
// Rank selection of the rank filter: ranks the nine samples, then picks one.
// Depends on rf_pkg; two register stages, the second being the result register.
module rf_rank_unit
   import rf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  window_type           win,
   input  logic                 in_last,
   input  logic [RANK_BITS-1:0] rank_k,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pixel_type            rsp_value,
   output logic                 rsp_frame_end
);

   logic                 va_ff;
   window_type           win_a_ff;
   logic [RANK_BITS-1:0] rank_a_ff [WIN_SIZE];
   logic [RANK_BITS-1:0] rank_in [WIN_SIZE];
   logic                 last_a_ff;
   logic                 ov_ff;
   pixel_type            value_ff;
   pixel_type            value_in;
   logic                 last_o_ff;
   logic                 en_o;
   logic                 en_a;

   assign en_o     = !ov_ff || rsp_ready;
   assign en_a     = !va_ff || en_o;
   assign in_ready = en_a;

   // Each sample's sorted position; ties go to the lower index first.
   always_comb begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         rank_in[i] = '0;
         for (int j = 0; j < WIN_SIZE; j++) begin
            if (j < i) begin
               if (win[j] <= win[i]) begin
                  rank_in[i] = rank_in[i] + RANK_BITS'(1);
               end
            end else if (j > i) begin
               if (win[j] < win[i]) begin
                  rank_in[i] = rank_in[i] + RANK_BITS'(1);
               end
            end
         end
      end
   end

   // The positions are all different, so exactly one sample matches.
   always_comb begin
      value_in = '0;
      for (int i = 0; i < WIN_SIZE; i++) begin
         if (rank_a_ff[i] == rank_k) begin
            value_in = value_in | win_a_ff[i];
         end
      end
   end

   // Valid flags of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= in_valid;
         end
         if (en_o) begin
            ov_ff <= va_ff;
         end
      end
   end

   // Payload of both stages.
   always_ff @(posedge clock) begin
      if (en_a) begin
         win_a_ff  <= win;
         rank_a_ff <= rank_in;
         last_a_ff <= in_last;
      end
      if (en_o) begin
         value_ff  <= value_in;
         last_o_ff <= last_a_ff;
      end
   end

   assign rsp_valid     = ov_ff;
   assign rsp_value     = value_ff;
   assign rsp_frame_end = last_o_ff;

endmodule

/* hdl/rank_filter_3x3.sv */
// Top level of the streaming 3x3 rank filter.
// Depends on rf_pkg, rf_line_store, rf_column_cell, rf_rank_unit and the defines header.
`include "rank_filter_3x3_defines.svh"

// The filter takes one pixel or flush item per clock cycle while req_ready is
// high and returns, for every pixel of the frame, the sample of the chosen
// rank in its 3x3 neighbourhood (rank 0 minimum, 4 median, 8 maximum), with
// edges reflected about the centre pixel. Results lag the input by
// image_width + 1 pixels; after the last pixel of a frame, image_width + 1
// flush items drain the rest, and flush items at any other time give nothing.
// rsp_valid rises after the item that causes it has passed the stage one, two
// and three registers and both stages of the rank unit.
// The line store is four row banks of MAX_WIDTH pixels, each written once and
// read at two columns per cycle, so one item per cycle is sustained while
// nothing stalls. After reset and after every configuration write the
// position counters are rebuilt with one shared multiplier, which holds
// req_ready low while it steps through its HW, IN and OUT states.
module rank_filter_3x3
   import rf_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  pixel_type                req_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pixel_type                rsp_value,
   output logic                     rsp_frame_end,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EX = CW + 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int NW = ROW_BITS + WW;
   localparam int EW = (WW > IW_BITS) ? WW : IW_BITS;

   // Recompute sequencer codes.
   localparam logic [1:0] RC_IDLE = 2'd0;
   localparam logic [1:0] RC_HW   = 2'd1;
   localparam logic [1:0] RC_IN   = 2'd2;
   localparam logic [1:0] RC_OUT  = 2'd3;

   logic [IW_BITS-1:0]   iw_ff;
   logic [ROW_BITS-1:0]  ih_ff;
   logic [RANK_BITS-1:0] rank_ff;
   logic [RANK_BITS-1:0] rank_k;
   logic [EW-1:0]        iw_ext;
   logic [WW-1:0]        w_eff;
   logic [ROW_BITS-1:0]  h_eff;
   logic [EX-1:0]        w_x;

   logic [1:0]           rc_state_ff;
   logic [1:0]           rc_state_in;
   logic [ROW_BITS-1:0]  mul_a;
   logic [NW-1:0]        prod;

   logic [CW-1:0]        in_col_ff;
   logic [CW-1:0]        in_col_in;
   logic [ROW_BITS-1:0]  in_row_ff;
   logic [ROW_BITS-1:0]  in_row_in;
   logic [CW-1:0]        out_col_ff;
   logic [CW-1:0]        out_col_in;
   logic [ROW_BITS-1:0]  out_row_ff;
   logic [ROW_BITS-1:0]  out_row_in;
   logic [NW-1:0]        n_in_ff;
   logic [NW-1:0]        n_in_in;
   logic [NW-1:0]        n_out_ff;
   logic [NW-1:0]        n_out_in;
   logic [NW-1:0]        hw_ff;
   logic                 frame_full_ff;
   logic                 frame_full_in;

   logic                 acc;
   logic                 is_pix;
   logic                 in_wrap;
   logic                 in_last;
   logic [NW-1:0]        n_in_base;
   logic [NW:0]          n_in_wrap;
   logic [NW-1:0]        n_in_nx;
   logic [CW-1:0]        oc_b;
   logic [ROW_BITS-1:0]  or_b;
   logic [NW-1:0]        no_b;
   logic                 emit_pix;
   logic                 emit;
   logic                 o_wrap;
   logic                 o_last;
   logic [NW:0]          n_out_wrap;
   logic [NW-1:0]        n_out_adv;
   slots_type            slots_in;
   logic [CW-1:0]        addr_r_in;

   logic                 en1;
   logic                 en2;
   logic                 en3;
   logic                 en4;
   logic                 v1_ff;
   slots_type            slots1_ff;
   logic [CW-1:0]        addr_c1_ff;
   logic [CW-1:0]        addr_r1_ff;
   logic                 first1_ff;
   logic                 last1_ff;
   logic                 v2_ff;
   logic                 first2_ff;
   logic                 last2_ff;
   logic                 v3_ff;
   logic                 last3_ff;
   column_type           fresh_c;
   column_type           fresh_r;
   column_type           cell_l;
   column_type           cell_c;
   column_type           cell_r;
   logic                 cell_load;
   window_type           win;

   // Effective frame size and rank: out-of-range settings are clamped.
   assign iw_ext = EW'(iw_ff);
   always_comb begin
      if (iw_ext < EW'(2)) begin
         w_eff = WW'(2);
      end else if (iw_ext > EW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(iw_ext);
      end
   end
   assign h_eff  = (ih_ff < 12'd2) ? 12'd2 : ih_ff;
   assign w_x    = EX'(w_eff);
   assign rank_k = (rank_ff > RANK_MAX) ? RANK_MAX : rank_ff;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff   <= IW_RESET;
         ih_ff   <= IH_RESET;
         rank_ff <= RANK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  iw_ff   <= csr_data[IW_BITS-1:0];
            CSR_IMAGE_HEIGHT: ih_ff   <= csr_data[ROW_BITS-1:0];
            CSR_RANK_SELECT:  rank_ff <= csr_data[RANK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Recompute sequencer: rebuilds the linear pixel counts with one multiplier.
   always_comb begin
      unique case (rc_state_ff)
         RC_HW:   mul_a = h_eff;
         RC_IN:   mul_a = in_row_ff;
         RC_OUT:  mul_a = out_row_ff;
         default: mul_a = '0;
      endcase
   end
   assign prod = {{WW{1'b0}}, mul_a} * {{ROW_BITS{1'b0}}, w_eff};

   always_comb begin
      if (csr_valid && csr_ready) begin
         rc_state_in = RC_HW;
      end else begin
         unique case (rc_state_ff)
            RC_HW:   rc_state_in = RC_IN;
            RC_IN:   rc_state_in = RC_OUT;
            default: rc_state_in = RC_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_state_ff <= RC_HW;
      end else begin
         rc_state_ff <= rc_state_in;
      end
   end

   // Pipeline enables; each stage moves when the one after it has room.
   assign en1       = !v1_ff || en2;
   assign en2       = !v2_ff || en3;
   assign en3       = !v3_ff || en4;
   assign req_ready = en1 && (rc_state_ff == RC_IDLE);
   assign acc       = req_valid && req_ready;
   assign is_pix    = (req_kind == KIND_PIXEL);

   // Input position advance and the pixel count after this pixel.
   assign in_wrap   = (EX'(in_col_ff) + EX'(1)) >= w_x;
   assign in_last   = in_wrap && (({1'b0, in_row_ff} + 13'd1) >= {1'b0, h_eff});
   assign n_in_base = frame_full_ff ? '0 : n_in_ff;
   assign n_in_wrap = {1'b0, n_in_base} + (NW+1)'(w_eff) - (NW+1)'(in_col_ff);
   always_comb begin
      if (in_last) begin
         n_in_nx = hw_ff;
      end else if (in_wrap) begin
         n_in_nx = n_in_wrap[NW-1:0];
      end else begin
         n_in_nx = n_in_base + NW'(1);
      end
   end

   // A pixel after the frame end restarts the output position.
   assign oc_b = (is_pix && frame_full_ff) ? '0 : out_col_ff;
   assign or_b = (is_pix && frame_full_ff) ? '0 : out_row_ff;
   assign no_b = (is_pix && frame_full_ff) ? '0 : n_out_ff;

   assign emit_pix = {1'b0, n_in_nx} >= ({1'b0, no_b} + (NW+1)'(w_eff) + (NW+1)'(2));
   assign emit     = acc && (is_pix ? emit_pix : frame_full_ff);

   // Output position advance.
   assign o_wrap     = (EX'(oc_b) + EX'(1)) >= w_x;
   assign o_last     = o_wrap && (({1'b0, or_b} + 13'd1) >= {1'b0, h_eff});
   assign n_out_wrap = {1'b0, no_b} + (NW+1)'(w_eff) - (NW+1)'(oc_b);
   always_comb begin
      if (o_last) begin
         n_out_adv = '0;
      end else if (o_wrap) begin
         n_out_adv = n_out_wrap[NW-1:0];
      end else begin
         n_out_adv = no_b + NW'(1);
      end
   end

   // Window rows and columns, reflected at the frame edges.
   always_comb begin
      slots_in.mid = or_b[SLOT_BITS-1:0];
      slots_in.up  = (or_b == '0) ? or_b[SLOT_BITS-1:0] + 2'd1 : or_b[SLOT_BITS-1:0] - 2'd1;
      slots_in.dn  = (({1'b0, or_b} + 13'd1) >= {1'b0, h_eff})
                     ? or_b[SLOT_BITS-1:0] - 2'd1 : or_b[SLOT_BITS-1:0] + 2'd1;
      addr_r_in    = o_wrap ? oc_b - CW'(1) : oc_b + CW'(1);
   end

   // Next values of the position state.
   always_comb begin
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      n_in_in       = n_in_ff;
      n_out_in      = n_out_ff;
      frame_full_in = frame_full_ff;
      if (rc_state_ff == RC_IN) begin
         n_in_in = frame_full_ff ? hw_ff : prod + NW'(in_col_ff);
      end else if (rc_state_ff == RC_OUT) begin
         n_out_in = prod + NW'(out_col_ff);
      end else if (acc) begin
         if (is_pix) begin
            n_in_in    = n_in_nx;
            out_col_in = oc_b;
            out_row_in = or_b;
            n_out_in   = no_b;
            if (in_last) begin
               in_col_in = '0;
               in_row_in = '0;
            end else if (in_wrap) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_BITS'(1);
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
         end
         if (emit) begin
            n_out_in = n_out_adv;
            if (o_last) begin
               out_col_in = '0;
               out_row_in = '0;
            end else if (o_wrap) begin
               out_col_in = '0;
               out_row_in = or_b + ROW_BITS'(1);
            end else begin
               out_col_in = oc_b + CW'(1);
            end
         end
         frame_full_in = (is_pix ? in_last : frame_full_ff) && !(emit && o_last);
         // Once the frame has fully drained the input count starts again from zero.
         if (emit && o_last) begin
            n_in_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         n_in_ff       <= '0;
         n_out_ff      <= '0;
         frame_full_ff <= 1'b0;
      end else begin
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         n_in_ff       <= n_in_in;
         n_out_ff      <= n_out_in;
         frame_full_ff <= frame_full_in;
      end
   end

   // Pixel count of a whole frame, rebuilt by the sequencer.
   always_ff @(posedge clock) begin
      if (rc_state_ff == RC_HW) begin
         hw_ff <= prod;
      end
   end

   // Stage one: read addresses of the result being produced.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= emit;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && emit) begin
         slots1_ff  <= slots_in;
         addr_c1_ff <= oc_b;
         addr_r1_ff <= addr_r_in;
         first1_ff  <= (oc_b == '0);
         last1_ff   <= o_last;
      end
      if (en2) begin
         first2_ff <= first1_ff;
         last2_ff  <= last1_ff;
      end
      if (en3) begin
         last3_ff <= last2_ff;
      end
   end

   // Line store: the pixel is written on transfer; reads use the stage one addresses.
   rf_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (acc && is_pix),
      .wr_slot   (in_row_ff[SLOT_BITS-1:0]),
      .wr_addr   (in_col_ff),
      .wr_data   (req_pixel),
      .rd_en     (en2),
      .rd_slots  (slots1_ff),
      .rd_addr_c (addr_c1_ff),
      .rd_addr_r (addr_r1_ff),
      .center    (fresh_c),
      .right     (fresh_r)
   );

   // Window cells: columns move one place left per result; a row start reloads.
   assign cell_load = en3 && v2_ff;

   rf_column_cell u_cell_r (
      .clock    (clock),
      .load     (cell_load),
      .take_alt (1'b0),
      .nb_in    (fresh_r),
      .alt_in   (fresh_r),
      .col_out  (cell_r)
   );

   rf_column_cell u_cell_c (
      .clock    (clock),
      .load     (cell_load),
      .take_alt (first2_ff),
      .nb_in    (cell_r),
      .alt_in   (fresh_c),
      .col_out  (cell_c)
   );

   rf_column_cell u_cell_l (
      .clock    (clock),
      .load     (cell_load),
      .take_alt (first2_ff),
      .nb_in    (cell_c),
      .alt_in   (fresh_r),
      .col_out  (cell_l)
   );

   assign win = {cell_l.up, cell_l.mid, cell_l.dn,
                 cell_c.up, cell_c.mid, cell_c.dn,
                 cell_r.up, cell_r.mid, cell_r.dn};

   // Ranking and the result register.
   rf_rank_unit u_rank (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (v3_ff),
      .in_ready      (en4),
      .win           (win),
      .in_last       (last3_ff),
      .rank_k        (rank_k),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_frame_end (rsp_frame_end)
   );

   // Checks on the sequencer, the frame state and the window cells.
   `RF_ASSERT(a_no_accept_busy, (rc_state_ff != RC_IDLE) |-> !req_ready)
   `RF_ASSERT(a_full_at_origin, frame_full_ff |-> (in_col_ff == '0 && in_row_ff == '0))
   `RF_ASSERT(a_cells_hold, (v3_ff && !en4) |=> (v3_ff && $stable(win)))
   `RF_ASSERT_RESET(a_reset_recompute, reset |=> (rc_state_ff == RC_HW))

endmodule
